// ===== hdl/sicd_pkg.sv =====
// Shared types and character codes for the serial I/O command decoder.
// No dependencies.
package sicd_pkg;

    localparam logic [7:0] CH_HIGH   = 8'd72;   // 'H'
    localparam logic [7:0] CH_LOW    = 8'd76;   // 'L'
    localparam logic [7:0] CH_ANALOG = 8'd65;   // 'A'
    localparam logic [7:0] CH_DOOR   = 8'd68;   // 'D'
    localparam logic [7:0] CH_TEMP   = 8'd84;   // 'T'
    localparam logic [7:0] CH_ZERO   = 8'd48;   // '0'
    localparam logic [7:0] ALARM_OFS = 8'd17;
    localparam logic [7:0] CH_ALARM  = CH_ZERO + ALARM_OFS;
    localparam logic [7:0] CH_DOOR8  = CH_ZERO + 8'd8;
    localparam logic [7:0] CH_DOOR9  = CH_ZERO + 8'd9;

    localparam logic [6:0] DOOR8_NUM = 7'd8;
    localparam logic [6:0] DOOR9_NUM = 7'd9;

    typedef enum logic [2:0] {
        ACT_SET    = 3'd0,
        ACT_ANALOG = 3'd1,
        ACT_TEMP   = 3'd2,
        ACT_HUMID  = 3'd3,
        ACT_ALARM  = 3'd4,
        ACT_DOOR   = 3'd5,
        ACT_BADPIN = 3'd6
    } t_action;

endpackage

// ===== hdl/sicd_if.sv =====
// Valid/ready channel interfaces for command words and result words.
// Depends on sicd_pkg.
interface sicd_cmd_if import sicd_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       byte_valid;
    logic [7:0] rx_byte;
    logic       door8_level;
    logic       door9_level;

    modport source (output valid, byte_valid, rx_byte, door8_level, door9_level,
                    input ready);
    modport sink   (input valid, byte_valid, rx_byte, door8_level, door9_level,
                    output ready);
endinterface

interface sicd_res_if import sicd_pkg::*; ();
    logic       valid;
    logic       ready;
    t_action    action;
    logic [6:0] pin_number;
    logic       pin_level;
    logic [7:0] analog_channel;
    logic       report_value;

    modport source (output valid, action, pin_number, pin_level, analog_channel,
                    report_value, input ready);
    modport sink   (input valid, action, pin_number, pin_level, analog_channel,
                    report_value, output ready);
endinterface

// ===== hdl/serial_io_command_decoder.sv =====
// Serial I/O command decoder: parses H/L/A/D command bytes into result words.
// A word accepted into the input register is decoded into the result register, and its
// result, if any, is valid on o_out from there; a held result stalls the decode.
// Throughput: one word per cycle unless stalled, set by the single decode stage between the input
// register and the result register. Synchronous active-low reset returns the parser
// to idle with both door flags set; no result is pending after reset. Needs sicd_pkg, sicd_if.
module serial_io_command_decoder
    import sicd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    sicd_cmd_if.sink     i_in,
    sicd_res_if.source   o_out
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TENS,
        ST_UNITS,
        ST_ANALOG,
        ST_DOOR
    } t_state;

    function automatic logic is_digit(input logic [7:0] b);
        return (b[7:4] == CH_ZERO[7:4]) && (b[3:0] <= 4'd9);
    endfunction

    // input register
    logic       r_in_valid;
    logic       r_byte_valid;
    logic [7:0] r_rx_byte;
    logic       r_door8_level;
    logic       r_door9_level;

    // parser state
    t_state     r_state,    n_state;
    logic       r_drive,    n_drive;
    logic [3:0] r_tens,     n_tens;
    logic       r_tens_ok,  n_tens_ok;
    logic       r_d8_flag,  n_d8_flag;
    logic       r_d9_flag,  n_d9_flag;

    // result register
    logic       r_out_valid;
    t_action    r_action,   n_action;
    logic [6:0] r_pin,      n_pin;
    logic       r_level,    n_level;
    logic [7:0] r_chan,     n_chan;
    logic       r_report,   n_report;
    logic       n_emit;

    logic       out_free;
    logic       step;
    logic [6:0] tens_x10;

    assign out_free   = !r_out_valid || o_out.ready;
    assign step       = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;
    assign tens_x10   = {r_tens, 3'b000} + {2'b00, r_tens, 1'b0};

    always_comb begin
        n_state   = r_state;
        n_drive   = r_drive;
        n_tens    = r_tens;
        n_tens_ok = r_tens_ok;
        n_d8_flag = r_d8_flag;
        n_d9_flag = r_d9_flag;
        n_emit    = 1'b0;
        n_action  = ACT_SET;
        n_pin     = '0;
        n_level   = 1'b0;
        n_chan    = '0;
        n_report  = 1'b0;

        // door levels only clear the door flags while idle, before the byte is decoded
        if (r_state == ST_IDLE) begin
            if (!r_door8_level) n_d8_flag = 1'b0;
            if (!r_door9_level) n_d9_flag = 1'b0;
        end

        if (r_byte_valid) begin
            unique case (r_state)
                ST_TENS: begin
                    n_tens_ok = is_digit(r_rx_byte);
                    n_tens    = is_digit(r_rx_byte) ? r_rx_byte[3:0] : 4'd0;
                    n_state   = ST_UNITS;
                end
                ST_UNITS: begin
                    n_state = ST_IDLE;
                    n_emit  = 1'b1;
                    n_level = r_drive;
                    if (r_tens_ok && is_digit(r_rx_byte)) begin
                        n_action = ACT_SET;
                        n_pin    = tens_x10 + {3'b000, r_rx_byte[3:0]};
                    end else begin
                        n_action = ACT_BADPIN;
                    end
                end
                ST_ANALOG: begin
                    n_state = ST_IDLE;
                    n_emit  = 1'b1;
                    if (r_rx_byte == CH_TEMP) begin
                        n_action = ACT_TEMP;
                    end else if (r_rx_byte == CH_HIGH) begin
                        n_action = ACT_HUMID;
                    end else begin
                        n_action = ACT_ANALOG;
                        n_chan   = r_rx_byte;
                    end
                end
                ST_DOOR: begin
                    n_state = ST_IDLE;
                    if (r_rx_byte == CH_ALARM) begin
                        n_emit   = 1'b1;
                        n_action = ACT_ALARM;
                        n_pin    = DOOR8_NUM;
                        n_report = !r_d8_flag;
                    end else if (r_rx_byte == CH_DOOR8) begin
                        n_emit    = 1'b1;
                        n_action  = ACT_DOOR;
                        n_pin     = DOOR8_NUM;
                        n_report  = r_d8_flag;
                        n_d8_flag = 1'b1;
                    end else if (r_rx_byte == CH_DOOR9) begin
                        n_emit    = 1'b1;
                        n_action  = ACT_DOOR;
                        n_pin     = DOOR9_NUM;
                        n_report  = r_d9_flag;
                        n_d9_flag = 1'b1;
                    end
                end
                default: begin
                    if (r_rx_byte == CH_HIGH || r_rx_byte == CH_LOW) begin
                        n_drive = (r_rx_byte == CH_HIGH);
                        n_state = ST_TENS;
                    end else if (r_rx_byte == CH_ANALOG) begin
                        n_state = ST_ANALOG;
                    end else if (r_rx_byte == CH_DOOR) begin
                        n_state = ST_DOOR;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= ST_IDLE;
            r_drive     <= 1'b0;
            r_tens      <= '0;
            r_tens_ok   <= 1'b0;
            r_d8_flag   <= 1'b1;
            r_d9_flag   <= 1'b1;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end

            if (step) begin
                r_state     <= n_state;
                r_drive     <= n_drive;
                r_tens      <= n_tens;
                r_tens_ok   <= n_tens_ok;
                r_d8_flag   <= n_d8_flag;
                r_d9_flag   <= n_d9_flag;
                r_out_valid <= n_emit;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end

        if (i_in.valid && i_in.ready) begin
            r_byte_valid  <= i_in.byte_valid;
            r_rx_byte     <= i_in.rx_byte;
            r_door8_level <= i_in.door8_level;
            r_door9_level <= i_in.door9_level;
        end

        if (step && n_emit) begin
            r_action <= n_action;
            r_pin    <= n_pin;
            r_level  <= n_level;
            r_chan   <= n_chan;
            r_report <= n_report;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.action         = r_action;
    assign o_out.pin_number     = r_pin;
    assign o_out.pin_level      = r_level;
    assign o_out.analog_channel = r_chan;
    assign o_out.report_value   = r_report;

endmodule
